// File: src/rpa_pkg.sv
// Shared types and constants for the reference-counted page allocator.
package rpa_pkg;

  localparam int unsigned NUM_PAGES_DEF   = 65536;
  localparam int unsigned PAGE_SHIFT_DEF  = 12;
  localparam int unsigned COUNT_WIDTH_DEF = 8;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LOW_PAGE_W  = 16;
  localparam int unsigned TOP_PAGE_W  = 17;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned REF_OUT_W   = 8;
  localparam int unsigned FREE_OUT_W  = 17;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 3'd0,
    FUNC_FREE  = 3'd1,
    FUNC_INC   = 3'd2,
    FUNC_DEC   = 3'd3,
    FUNC_READ  = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MEM   = 2'd1,
    STAT_BAD_ADDR = 2'd2,
    STAT_LIMIT    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWEST_FREE = 1'b0,
    CFG_TOP_PAGE    = 1'b1
  } cfg_idx_e;

endpackage

// File: src/rpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/refcounted_page_allocator.sv
// Page allocator top level: free-page stack, per-page reference counts, request sequencer.
// A request accepted in the idle state is held in the execute state; its result is then
// registered for output once the output register is free. No new request is accepted until
// then; the count and stack memories are read on the accept beat, ahead of the write-back.
// Reset: after rst_ni is released, a clearing pass writes zero to all NUM_PAGES
// count entries, one per cycle; requests are held off until the pass has ended.
module refcounted_page_allocator
  import rpa_pkg::*;
#(
  parameter int unsigned NUM_PAGES   = NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [2:0] func, [34:3] page_addr, [39:35] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [1:0] status, [33:2] alloc_addr, [41:34] ref_count, [58:42] free_pages, [63:59] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned PAGE_W  = $clog2(NUM_PAGES);
  localparam int unsigned DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int unsigned PFULL_W = ADDR_W + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                  state_q, state_d;
  logic [PAGE_W-1:0]       clr_q, clr_d;
  logic [DEPTH_W-1:0]      depth_q, depth_d;
  logic [FUNC_W-1:0]       op_q, op_d;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic                    ovalid_q, ovalid_d;
  status_e                 stat_q, stat_d;
  logic [ADDR_W-1:0]       alloc_q, alloc_d;
  logic [REF_OUT_W-1:0]    refo_q, refo_d;
  logic [FREE_OUT_W-1:0]   freeo_q, freeo_d;
  logic [LOW_PAGE_W-1:0]   low_page_q;
  logic [TOP_PAGE_W-1:0]   top_page_q;

  logic                    s_fire, out_free, go;
  logic [ADDR_W-1:0]       in_addr;
  logic [PFULL_W-1:0]      in_page, page;
  logic [PAGE_W-1:0]       pidx;
  logic [DEPTH_W-1:0]      depth_m1;
  logic                    in_range, bad_free;

  logic                    cnt_we;
  logic [PAGE_W-1:0]       cnt_waddr;
  logic [COUNT_WIDTH-1:0]  cnt_wdata, cnt_rd, cnt_new, cnt_out;
  logic [PAGE_W-1:0]       cnt_raddr;
  logic                    stk_we;
  logic [PAGE_W-1:0]       stk_waddr, stk_raddr, stk_rd;
  logic [31:0]             cnt_ext, depth_ext;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_page_q <= '0;
      top_page_q <= TOP_PAGE_W'(65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOWEST_FREE: low_page_q <= cfg_data_i[LOW_PAGE_W-1:0];
        CFG_TOP_PAGE:    top_page_q <= cfg_data_i[TOP_PAGE_W-1:0];
        default:         ;
      endcase
    end
  end

  // Read addresses, issued on the accept beat
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_addr         = s_axis_tdata_i[FUNC_W +: ADDR_W];
  assign in_page         = {1'b0, in_addr} >> PAGE_SHIFT;
  assign cnt_raddr       = in_page[PAGE_W-1:0];
  assign depth_m1        = depth_q - 1'b1;
  assign stk_raddr       = depth_m1[PAGE_W-1:0];

  // Request decode for the execute beat
  assign page     = {1'b0, addr_q} >> PAGE_SHIFT;
  assign pidx     = page[PAGE_W-1:0];
  assign in_range = (page < PFULL_W'(top_page_q)) && (page < PFULL_W'(NUM_PAGES));
  assign bad_free = (addr_q[PAGE_SHIFT-1:0] != '0) || (page < PFULL_W'(low_page_q)) ||
                    !in_range;
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign go       = (state_q == S_EXEC) && out_free;

  always_comb begin
    stat_d    = STAT_OK;
    alloc_d   = '0;
    cnt_out   = '0;
    depth_d   = depth_q;
    cnt_we    = 1'b0;
    cnt_waddr = pidx;
    cnt_wdata = '0;
    stk_we    = 1'b0;
    stk_waddr = depth_q[PAGE_W-1:0];
    cnt_new   = (cnt_rd != '0) ? cnt_rd - 1'b1 : cnt_rd;
    case (func_e'(op_q))
      FUNC_ALLOC: begin
        if (depth_q == '0) begin
          stat_d = STAT_NO_MEM;
        end else begin
          depth_d   = depth_m1;
          cnt_we    = 1'b1;
          cnt_waddr = stk_rd;
          cnt_wdata = COUNT_WIDTH'(1);
          alloc_d   = ADDR_W'(stk_rd) << PAGE_SHIFT;
          cnt_out   = COUNT_WIDTH'(1);
        end
      end
      FUNC_FREE: begin
        if (bad_free) begin
          stat_d = STAT_BAD_ADDR;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_new;
          cnt_out   = cnt_new;
          if (cnt_new == '0) begin
            if (depth_q >= DEPTH_W'(NUM_PAGES)) begin
              stat_d = STAT_LIMIT;
            end else begin
              stk_we  = 1'b1;
              depth_d = depth_q + 1'b1;
            end
          end
        end
      end
      FUNC_INC: begin
        if (!in_range) begin
          stat_d = STAT_BAD_ADDR;
        end else if (cnt_rd == {COUNT_WIDTH{1'b1}}) begin
          stat_d  = STAT_LIMIT;
          cnt_out = cnt_rd;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd + 1'b1;
          cnt_out   = cnt_wdata;
        end
      end
      FUNC_DEC: begin
        if (!in_range) begin
          stat_d = STAT_BAD_ADDR;
        end else if (cnt_rd == '0) begin
          stat_d = STAT_LIMIT;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_new;
          cnt_out   = cnt_new;
        end
      end
      FUNC_READ: begin
        if (!in_range) begin
          stat_d = STAT_BAD_ADDR;
        end else begin
          cnt_out = cnt_rd;
        end
      end
      default: ;
    endcase
    if (state_q == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
    end else if (!go) begin
      cnt_we  = 1'b0;
      stk_we  = 1'b0;
      depth_d = depth_q;
    end
  end

  assign cnt_ext   = 32'(cnt_out);
  assign depth_ext = 32'(depth_d);
  assign refo_d    = cnt_ext[REF_OUT_W-1:0];
  assign freeo_d   = depth_ext[FREE_OUT_W-1:0];

  // Sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    op_d     = op_q;
    addr_d   = addr_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_fire) begin
          op_d    = s_axis_tdata_i[FUNC_W-1:0];
          addr_d  = in_addr;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      depth_q  <= '0;
      op_q     <= '0;
      addr_q   <= '0;
      ovalid_q <= 1'b0;
      stat_q   <= STAT_OK;
      alloc_q  <= '0;
      refo_q   <= '0;
      freeo_q  <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      depth_q  <= depth_d;
      op_q     <= op_d;
      addr_q   <= addr_d;
      ovalid_q <= ovalid_d;
      if (go) begin
        stat_q  <= stat_d;
        alloc_q <= alloc_d;
        refo_q  <= refo_d;
        freeo_q <= freeo_d;
      end
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'b0, freeo_q, refo_q, alloc_q, stat_q};

  rpa_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (s_fire),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  rpa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (pidx),
    .re_i    (s_fire),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(NUM_PAGES))
    else $error("free stack depth beyond page count");

  a_depth_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go |=> $stable(depth_q))
    else $error("free stack depth moved outside execute beat");

  a_no_mem_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && stat_q == STAT_NO_MEM) |-> (freeo_q == '0 && alloc_q == '0))
    else $error("out of memory reported with pages on the stack");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready_o && !stk_we)
    else $error("request taken during count clearing pass");

endmodule
